/* hdl/psr_pkg.sv */
// Shared types, codes and defaults for the per-producer sequence reorder block.
package psr_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int DEF_PRODUCERS = 16;
    localparam int DEF_CAPACITY  = 16;

    // Fixed field widths.
    localparam int SEQ_W  = 64;
    localparam int PAY_W  = 16;
    localparam int PROD_W = 4;

    // Number of distinct producer codes on the input field.
    localparam int PROD_CODES = 1 << PROD_W;

    // Input item modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_PURGE  = 1'b1;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_RELEASED = 3'd0,
        KIND_HELD     = 3'd1,
        KIND_DUP      = 3'd2,
        KIND_OVERFLOW = 3'd3,
        KIND_EMPTY    = 3'd4
    } t_kind;

    // One input beat.
    typedef struct packed {
        logic              mode;
        logic [PROD_W-1:0] producer;
        logic [SEQ_W-1:0]  seq_no;
        logic [SEQ_W-1:0]  first_seq_no;
        logic [PAY_W-1:0]  payload;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        t_kind             kind;
        logic [PROD_W-1:0] out_producer;
        logic [SEQ_W-1:0]  out_seq_no;
        logic [PAY_W-1:0]  out_payload;
        logic              last;
    } t_out_item;

    // Slot address selection for the held-entry store read port.
    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_REL,
        RA_IDX_REL
    } t_raddr_sel;

    // Source of the sequence number and handle of a result.
    typedef enum logic [1:0] {
        OS_INPUT,
        OS_ZERO,
        OS_READ,
        OS_PEND
    } t_out_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch_in;
        logic       latch_meta;
        logic       idx_from_cnt;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_dec;
        logic       cnt_inc;
        logic       rel_take;
        logic       wr_new;
        logic       wr_rd;
        logic       meta_wr;
        t_raddr_sel raddr_sel;
        logic       out_load;
        t_out_src   out_src;
        t_kind      out_kind;
        logic       out_last;
    } t_psr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_purge;
        logic dup;
        logic full;
        logic cnt_zero;
        logic idx_zero;
        logic idx_last;
        logic rd_le;
        logic rd_match;
        logic rel_done;
        logic rel_zero;
        logic cp_done;
        logic pend_vld;
        logic out_free;
    } t_psr_status;

endpackage

/* hdl/per_producer_sequence_reorder.sv */
// Per-producer sequence reorder buffer, top level.
//
// Input channel: i_in_valid / o_in_stall / i_in_data. An insert beat carries a
// producer, a sequence number, the sender's first number of its range and a
// buffer handle; a purge beat empties that producer's held entries in order.
// Output channel: o_out_valid / i_out_stall / o_out_data. Each input beat gives
// one or more result beats; the final one has last set.
// One item is worked on at a time; o_in_stall is high from the cycle after
// acceptance until the item is finished, including the write-back of the
// producer's expected number and fill count, which every item but a rejected insert does.
// A purge reads out each held entry in turn; an insert moves larger entries up
// to make room, releases the entries that are next in order and moves the rest down.
// A reject or an empty purge loads its result in the decode state.
// The held-entry store has a single read port with registered data: every step
// reads one slot and waits for its data.
// A stalled receiver holds the result register and the sequencer waits on it.
// Reset clears the expected numbers and fill counts of all producers through
// per-producer valid bits; no clearing pass is needed.
module per_producer_sequence_reorder
    import psr_pkg::*;
#(
    parameter int PRODUCERS = DEF_PRODUCERS,
    parameter int CAPACITY  = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_psr_cmd    w_cmd;
    t_psr_status w_status;

    // Sequencer.
    psr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // State, stores and result register.
    psr_dpath #(
        .PRODUCERS (PRODUCERS),
        .CAPACITY  (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/psr_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module psr_ram
    import psr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/psr_ctrl.sv */
// Controller state machine that sequences insert, release, compaction and purge.
module psr_ctrl
    import psr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_psr_status i_status,
    output t_psr_cmd    o_cmd,
    output logic        o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_META,
        S_DEC,
        S_PG_RD,
        S_PG_EM,
        S_SHIFT,
        S_SH_CMP,
        S_RL_RD,
        S_RL_CMP,
        S_RL_END,
        S_CP_RD,
        S_CP_WR,
        S_FIN
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_psr_cmd w_cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.latch_in = 1'b1;
                    n_state        = S_META;
                end
            end
            S_META: begin
                w_cmd.latch_meta = 1'b1;
                n_state          = S_DEC;
            end
            S_DEC: begin
                if (i_status.is_purge) begin
                    if (i_status.cnt_zero) begin
                        if (i_status.out_free) begin
                            w_cmd.out_load = 1'b1;
                            w_cmd.out_src  = OS_ZERO;
                            w_cmd.out_kind = KIND_EMPTY;
                            w_cmd.out_last = 1'b1;
                            n_state        = S_FIN;
                        end
                    end else begin
                        w_cmd.idx_clr = 1'b1;
                        n_state       = S_PG_RD;
                    end
                end else if (i_status.dup || i_status.full) begin
                    if (i_status.out_free) begin
                        w_cmd.out_load = 1'b1;
                        w_cmd.out_src  = OS_INPUT;
                        w_cmd.out_kind = i_status.dup ? KIND_DUP : KIND_OVERFLOW;
                        w_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    w_cmd.idx_from_cnt = 1'b1;
                    w_cmd.cnt_inc      = 1'b1;
                    n_state            = S_SHIFT;
                end
            end
            S_PG_RD: begin
                w_cmd.raddr_sel = RA_IDX;
                n_state         = S_PG_EM;
            end
            S_PG_EM: begin
                w_cmd.raddr_sel = RA_IDX;
                if (i_status.out_free) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.out_src  = OS_READ;
                    w_cmd.out_kind = KIND_RELEASED;
                    w_cmd.out_last = i_status.idx_last;
                    if (i_status.idx_last) begin
                        n_state = S_FIN;
                    end else begin
                        w_cmd.idx_inc = 1'b1;
                        n_state       = S_PG_RD;
                    end
                end
            end
            S_SHIFT: begin
                w_cmd.raddr_sel = RA_IDX_M1;
                if (i_status.idx_zero) begin
                    w_cmd.wr_new = 1'b1;
                    n_state      = S_RL_RD;
                end else begin
                    n_state = S_SH_CMP;
                end
            end
            S_SH_CMP: begin
                w_cmd.raddr_sel = RA_IDX_M1;
                if (i_status.rd_le) begin
                    w_cmd.wr_new = 1'b1;
                    n_state      = S_RL_RD;
                end else begin
                    w_cmd.wr_rd   = 1'b1;
                    w_cmd.idx_dec = 1'b1;
                    n_state       = S_SHIFT;
                end
            end
            S_RL_RD: begin
                w_cmd.raddr_sel = RA_REL;
                n_state         = i_status.rel_done ? S_RL_END : S_RL_CMP;
            end
            S_RL_CMP: begin
                w_cmd.raddr_sel = RA_REL;
                if (!i_status.rd_match) begin
                    n_state = S_RL_END;
                end else if (!i_status.pend_vld || i_status.out_free) begin
                    // The previous release is known not to be the last one.
                    w_cmd.out_load = i_status.pend_vld;
                    w_cmd.out_src  = OS_PEND;
                    w_cmd.out_kind = KIND_RELEASED;
                    w_cmd.rel_take = 1'b1;
                    n_state        = S_RL_RD;
                end
            end
            S_RL_END: begin
                if (i_status.out_free) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.out_src  = i_status.pend_vld ? OS_PEND : OS_INPUT;
                    w_cmd.out_kind = i_status.pend_vld ? KIND_RELEASED : KIND_HELD;
                    w_cmd.out_last = 1'b1;
                    if (i_status.rel_zero) begin
                        n_state = S_FIN;
                    end else begin
                        w_cmd.idx_clr = 1'b1;
                        n_state       = S_CP_RD;
                    end
                end
            end
            S_CP_RD: begin
                w_cmd.raddr_sel = RA_IDX_REL;
                n_state         = i_status.cp_done ? S_FIN : S_CP_WR;
            end
            S_CP_WR: begin
                w_cmd.raddr_sel = RA_IDX_REL;
                w_cmd.wr_rd     = 1'b1;
                w_cmd.idx_inc   = 1'b1;
                n_state         = S_CP_RD;
            end
            S_FIN: begin
                w_cmd.meta_wr = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* hdl/psr_dpath.sv */
// Datapath: item registers, per-producer state and held-entry stores, result register.
module psr_dpath
    import psr_pkg::*;
#(
    parameter int PRODUCERS = DEF_PRODUCERS,
    parameter int CAPACITY  = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in_data,
    input  t_psr_cmd    i_cmd,
    input  logic        i_out_stall,
    output t_psr_status o_status,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    localparam int PW     = (PRODUCERS > 1) ? $clog2(PRODUCERS) : 1;
    localparam int SW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int AW     = PW + SW;
    localparam int META_W = SEQ_W + CW;
    localparam int ENT_W  = SEQ_W + PAY_W;

    // Producer code reduced to a store index, worked out at elaboration.
    logic [PW-1:0] w_pmod [PROD_CODES];
    for (genvar g = 0; g < PROD_CODES; g++) begin : g_pmod
        assign w_pmod[g] = PW'(g % PRODUCERS);
    end

    t_in_item         r_in;
    logic [PW-1:0]    r_p;
    logic [SEQ_W-1:0] r_exp;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_rel;
    logic             r_pend_vld;
    logic [SEQ_W-1:0] r_pend_seq;
    logic [PAY_W-1:0] r_pend_pay;
    logic             r_out_vld;
    t_out_item        r_out;
    logic [PRODUCERS-1:0] r_meta_vld;

    logic [PW-1:0]     w_meta_raddr;
    logic [META_W-1:0] w_meta_wdata;
    logic [META_W-1:0] w_meta_rdata;
    logic [SW-1:0]     w_slot;
    logic [CW-1:0]     w_idx_m1;
    logic [CW-1:0]     w_idx_rel;
    logic [CW-1:0]     w_cnt_left;
    logic [ENT_W-1:0]  w_ent_wdata;
    logic [ENT_W-1:0]  w_ent_rdata;
    logic [SEQ_W-1:0]  w_rd_seq;
    logic [PAY_W-1:0]  w_rd_pay;
    logic              w_out_free;

    assign w_rd_seq   = w_ent_rdata[ENT_W-1:PAY_W];
    assign w_rd_pay   = w_ent_rdata[PAY_W-1:0];
    assign w_idx_m1   = r_idx - CW'(1);
    assign w_idx_rel  = r_idx + r_rel;
    assign w_cnt_left = r_cnt - r_rel;
    assign w_out_free = !r_out_vld || !i_out_stall;

    // Per-producer expected number and fill count.
    assign w_meta_raddr = i_cmd.latch_in ? w_pmod[i_in_data.producer] : r_p;
    assign w_meta_wdata = (r_in.mode == MODE_PURGE) ? '0 : {r_exp, w_cnt_left};

    psr_ram #(
        .WIDTH (META_W),
        .DEPTH (1 << PW)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.meta_wr),
        .i_waddr (r_p),
        .i_wdata (w_meta_wdata),
        .i_raddr (w_meta_raddr),
        .o_rdata (w_meta_rdata)
    );

    // Held-entry store, slot i of producer p at {p, i}.
    always_comb begin
        case (i_cmd.raddr_sel)
            RA_IDX:     w_slot = r_idx[SW-1:0];
            RA_IDX_M1:  w_slot = w_idx_m1[SW-1:0];
            RA_REL:     w_slot = r_rel[SW-1:0];
            RA_IDX_REL: w_slot = w_idx_rel[SW-1:0];
            default:    w_slot = r_idx[SW-1:0];
        endcase
    end

    assign w_ent_wdata = i_cmd.wr_new ? {r_in.seq_no, r_in.payload} : w_ent_rdata;

    psr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (1 << AW)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_new || i_cmd.wr_rd),
        .i_waddr ({r_p, r_idx[SW-1:0]}),
        .i_wdata (w_ent_wdata),
        .i_raddr ({r_p, w_slot}),
        .o_rdata (w_ent_rdata)
    );

    // Item, counter and pending-release registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in  <= i_in_data;
            r_p   <= w_pmod[i_in_data.producer];
            r_rel <= '0;
        end
        if (i_cmd.latch_meta) begin
            r_exp <= r_meta_vld[r_p] ? w_meta_rdata[META_W-1:CW] : '0;
            r_cnt <= r_meta_vld[r_p] ? w_meta_rdata[CW-1:0] : '0;
        end
        if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.idx_from_cnt) begin
            r_idx <= r_cnt;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= w_idx_m1;
        end
        if (i_cmd.rel_take) begin
            r_rel      <= r_rel + CW'(1);
            r_exp      <= w_rd_seq + SEQ_W'(1);
            r_pend_seq <= w_rd_seq;
            r_pend_pay <= w_rd_pay;
        end
    end

    // Control flags: pending release, per-producer valid bits, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_meta_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.latch_in) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.rel_take) begin
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.meta_wr) begin
                r_meta_vld[r_p] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.kind         <= i_cmd.out_kind;
            r_out.out_producer <= r_in.producer;
            r_out.last         <= i_cmd.out_last;
            case (i_cmd.out_src)
                OS_INPUT: begin
                    r_out.out_seq_no  <= r_in.seq_no;
                    r_out.out_payload <= r_in.payload;
                end
                OS_ZERO: begin
                    r_out.out_seq_no  <= '0;
                    r_out.out_payload <= '0;
                end
                OS_READ: begin
                    r_out.out_seq_no  <= w_rd_seq;
                    r_out.out_payload <= w_rd_pay;
                end
                OS_PEND: begin
                    r_out.out_seq_no  <= r_pend_seq;
                    r_out.out_payload <= r_pend_pay;
                end
                default: begin
                    r_out.out_seq_no  <= r_in.seq_no;
                    r_out.out_payload <= r_in.payload;
                end
            endcase
        end
    end

    // Status towards the controller.
    always_comb begin
        o_status.is_purge = (r_in.mode == MODE_PURGE);
        o_status.dup      = (r_in.seq_no < r_exp);
        o_status.full     = (r_cnt >= CW'(CAPACITY));
        o_status.cnt_zero = (r_cnt == '0);
        o_status.idx_zero = (r_idx == '0);
        o_status.idx_last = (r_idx == r_cnt - CW'(1));
        o_status.rd_le    = (w_rd_seq <= r_in.seq_no);
        o_status.rd_match = (w_rd_seq == r_in.first_seq_no) || (w_rd_seq == r_exp);
        o_status.rel_done = (r_rel == r_cnt);
        o_status.rel_zero = (r_rel == '0);
        o_status.cp_done  = (r_idx == w_cnt_left);
        o_status.pend_vld = r_pend_vld;
        o_status.out_free = w_out_free;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* tb/sv/per_producer_sequence_reorder_tb.sv */
// Self-checking testbench for the per-producer sequence reorder block.
module per_producer_sequence_reorder_tb
    import psr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROD    = DEF_PRODUCERS;
    localparam int NCAP     = DEF_CAPACITY;
    localparam int IDLE_MAX = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    per_producer_sequence_reorder #(
        .PRODUCERS(NPROD),
        .CAPACITY (NCAP)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Predictor state: next expected number and sorted held entries per producer.
    logic [SEQ_W-1:0] next_seq   [NPROD];
    int               fill       [NPROD];
    logic [SEQ_W-1:0] slot_seq   [NPROD][NCAP];
    logic [PAY_W-1:0] slot_pay   [NPROD][NCAP];

    t_out_item pending_results[$];
    int        errors;
    int        idle_cycles;
    bit        hold_off;
    bit        long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Queues one expected result beat.
    task automatic push_result(t_kind k, logic [PROD_W-1:0] p, logic [SEQ_W-1:0] s,
                               logic [PAY_W-1:0] d);
        t_out_item r;
        r.kind = k;
        r.out_producer = p;
        r.out_seq_no = s;
        r.out_payload = d;
        r.last = 1'b0;
        pending_results = {pending_results, r};
    endtask

    // Works out the result beats of one accepted item and updates the state.
    task automatic predict_reorder(t_in_item it);
        int p;
        int pos;
        int rel;
        int n0;
        t_out_item r;
        p = int'(it.producer) % NPROD;
        n0 = pending_results.size();
        if (it.mode == MODE_PURGE) begin
            for (int i = 0; i < fill[p]; i++)
                push_result(KIND_RELEASED, it.producer, slot_seq[p][i], slot_pay[p][i]);
            if (fill[p] == 0) push_result(KIND_EMPTY, it.producer, '0, '0);
            fill[p] = 0;
            next_seq[p] = '0;
        end else if (it.seq_no < next_seq[p]) begin
            push_result(KIND_DUP, it.producer, it.seq_no, it.payload);
        end else if (fill[p] >= NCAP) begin
            push_result(KIND_OVERFLOW, it.producer, it.seq_no, it.payload);
        end else begin
            pos = 0;
            while (pos < fill[p] && slot_seq[p][pos] <= it.seq_no) pos++;
            for (int i = fill[p]; i > pos; i--) begin
                slot_seq[p][i] = slot_seq[p][i-1];
                slot_pay[p][i] = slot_pay[p][i-1];
            end
            slot_seq[p][pos] = it.seq_no;
            slot_pay[p][pos] = it.payload;
            fill[p]++;
            rel = 0;
            while (rel < fill[p] && (slot_seq[p][rel] == it.first_seq_no ||
                                     slot_seq[p][rel] == next_seq[p])) begin
                next_seq[p] = slot_seq[p][rel] + 1'b1;
                push_result(KIND_RELEASED, it.producer, slot_seq[p][rel], slot_pay[p][rel]);
                rel++;
            end
            for (int i = 0; i + rel < fill[p]; i++) begin
                slot_seq[p][i] = slot_seq[p][i+rel];
                slot_pay[p][i] = slot_pay[p][i+rel];
            end
            fill[p] -= rel;
            if (rel == 0) push_result(KIND_HELD, it.producer, it.seq_no, it.payload);
        end
        r = pending_results[pending_results.size()-1];
        r.last = 1'b1;
        pending_results[pending_results.size()-1] = r;
        if (pending_results.size() == n0) errors++;
    endtask

    // Offers one beat after a random gap and waits for acceptance; valid stays
    // high after acceptance until the next beat or the end of the run.
    task automatic send_beat(t_in_item it, bit no_gap = 1'b0);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (no_gap || $urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_reorder(it);
    endtask

    function automatic t_in_item make_item(logic mode, int p, logic [SEQ_W-1:0] s,
                                           logic [SEQ_W-1:0] f, logic [PAY_W-1:0] d);
        t_in_item it;
        it.mode = mode;
        it.producer = PROD_W'(p);
        it.seq_no = s;
        it.first_seq_no = f;
        it.payload = d;
        return it;
    endfunction

    function automatic logic [SEQ_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Extremes, each result kind, equal numbers, wrap and overflow.
    task automatic test_directed();
        logic [SEQ_W-1:0] top;
        top = '1;
        send_beat(make_item(MODE_PURGE, 3, '0, '0, '0));
        send_beat(make_item(MODE_INSERT, 0, 64'd2, 64'd9, 16'h1234));
        send_beat(make_item(MODE_INSERT, 0, 64'd2, 64'd9, 16'hFFFF));
        send_beat(make_item(MODE_INSERT, 0, 64'd1, 64'd9, 16'h0001));
        send_beat(make_item(MODE_INSERT, 0, 64'd0, 64'd9, 16'h0000));
        send_beat(make_item(MODE_INSERT, 0, 64'd1, 64'd0, 16'h00AA));
        send_beat(make_item(MODE_INSERT, 15, top, top, 16'hFFFF));
        send_beat(make_item(MODE_INSERT, 15, 64'd0, top, 16'h5555));
        send_beat(make_item(MODE_INSERT, 15, top - 1, 64'd5, 16'hAAAA));
        send_beat(make_item(MODE_PURGE, 15, top, top, 16'hFFFF));
        for (int i = 0; i < NCAP + 1; i++)
            send_beat(make_item(MODE_INSERT, 7, 64'd100 + i, 64'd0, 16'(i)));
        send_beat(make_item(MODE_INSERT, 7, 64'd1, 64'd1, 16'h7777));
        send_beat(make_item(MODE_PURGE, 7, '0, '0, '0));
    endtask

    // Mostly shuffled runs per producer, with noise and broken sequences.
    task automatic test_random(int n_items);
        int sent;
        int p;
        int len;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] seqs[$];
        sent = 0;
        while (sent < n_items) begin
            p = $urandom_range(0, NPROD - 1);
            case ($urandom_range(0, 9))
                0: begin
                    send_beat(make_item(MODE_INSERT, p, rand64(), rand64(), 16'($urandom())));
                    sent++;
                end
                1: begin
                    send_beat(make_item(MODE_PURGE, p, rand64(), rand64(), 16'($urandom())));
                    sent++;
                end
                default: begin
                    len = $urandom_range(1, 8);
                    base = ($urandom_range(0, 7) == 0) ? 64'hFFFF_FFFF_FFFF_FFF8 - len :
                           next_seq[p] + $urandom_range(0, 2);
                    seqs.delete();
                    for (int i = 0; i < len; i++) seqs = {seqs, base + i};
                    seqs.shuffle();
                    if ($urandom_range(0, 3) == 0) seqs = {seqs, base};
                    foreach (seqs[i]) begin
                        send_beat(make_item(MODE_INSERT, p, seqs[i],
                                            ($urandom_range(0, 2) == 0) ? base : rand64(),
                                            16'($urandom())));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // Receiver stops for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_beat(make_item(MODE_INSERT, i % 4, 64'd500 + i, 64'd500, 16'(i)), 1'b1);
        long_hold_req = 1'b0;
    endtask

    // Receiver stall pattern, including one long hold-off on request.
    initial begin
        int gap;
        i_out_stall = 1'b1;
        hold_off = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_off) begin
                hold_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
                i_out_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 5) == 0) repeat ($urandom_range(5, 30)) @(negedge i_clk);
            end
        end
    end

    // Compares each accepted result beat with the oldest expectation.
    initial begin
        t_out_item exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result beat kind=%0d seq=%0h", o_out_data.kind,
                           o_out_data.out_seq_no);
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_out_data.kind !== exp_r.kind) begin
                        $error("kind: expected %0d actual %0d", exp_r.kind, o_out_data.kind);
                        errors++;
                    end
                    if (o_out_data.out_producer !== exp_r.out_producer) begin
                        $error("out_producer: expected %0d actual %0d", exp_r.out_producer,
                               o_out_data.out_producer);
                        errors++;
                    end
                    if (o_out_data.out_seq_no !== exp_r.out_seq_no) begin
                        $error("out_seq_no: expected %0h actual %0h", exp_r.out_seq_no,
                               o_out_data.out_seq_no);
                        errors++;
                    end
                    if (o_out_data.out_payload !== exp_r.out_payload) begin
                        $error("out_payload: expected %0h actual %0h", exp_r.out_payload,
                               o_out_data.out_payload);
                        errors++;
                    end
                    if (o_out_data.last !== exp_r.last) begin
                        $error("last: expected %0b actual %0b", exp_r.last, o_out_data.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("per_producer_sequence_reorder regression: fail");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        for (int p = 0; p < NPROD; p++) begin
            next_seq[p] = '0;
            fill[p] = 0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(280);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("per_producer_sequence_reorder regression: pass");
        else
            $display("per_producer_sequence_reorder regression: fail");
        $finish;
    end
endmodule

/* files.f */
hdl/psr_pkg.sv
hdl/psr_ram.sv
hdl/psr_ctrl.sv
hdl/psr_dpath.sv
hdl/per_producer_sequence_reorder.sv
tb/sv/per_producer_sequence_reorder_tb.sv
